@@ src/bhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

    // default sizing
    localparam int MAX_LEN_DEF  = 4096;
    localparam int ALPHABET_DEF = 256;

    // size accumulator and summary field width
    localparam int SIZE_W   = 10;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;

    // encoding costs and digit limits
    localparam int COST_NEW      = 2;
    localparam int DIGIT_SPLIT   = 10;
    localparam int TWO_DIGIT_MAX = 99;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // result kinds, carried on the output tuser
    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_ENTRY   = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    // tens digit of a value up to 99: multiply by 205/2048
    function automatic logic [3:0] digit_tens(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

endpackage

`default_nettype wire

@@ src/byte_histogram_compressor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte: accepted in idle, then a read-modify-write of the count memory;
// a byte dropped past the length limit skips the memory update.
// Last byte: the summary word is loaded after the count update.
// Drain word: the scan steps past empty entries to the next entry, or to the end.
// A full output register holds a summary or drain step until the word is taken.
// Reset is synchronous, active low; the table clears at once via valid bits.
module byte_histogram_compressor
    import bhc_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF,
    localparam int CW        = $clog2(MAX_LEN + 1),
    localparam int OUT_W     = 8 + CW + 8 + 8 + 1 + 1 + SIZE_W + 1 + 1,
    localparam int OUT_BYTES = (OUT_W + 7) / 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,  // data_byte
    input  wire logic [0:0]             i_s_tuser,  // cmd
    input  wire logic                   i_s_tlast,  // last
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // symbol, count, tens_char, ones_char, two_digits, too_large,
    // compressed_len, use_compressed, overflow
    output logic [OUT_BYTES*8-1:0]      o_m_tdata,
    output logic [1:0]                  o_m_tuser   // kind
);

    localparam int AW = $clog2(ALPHABET);
    localparam int PW = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_SUM,
        S_SCAN
    } t_state;

    t_state                 r_state, n_state;
    logic [SIZE_W-1:0]      r_size, n_size;
    logic [CW-1:0]          r_len, n_len;
    logic [PW-1:0]          r_ptr, n_ptr;
    logic                   r_ovf, n_ovf;
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_last, n_last;
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [OUT_BYTES*8-1:0] r_out_data, n_out_data;

    logic          mem_rd_en, mem_wr_en, mem_clear;
    logic [AW-1:0] mem_rd_addr;
    logic [CW-1:0] mem_rd_data, mem_wr_data;

    logic                out_free;
    logic                ptr_in;
    logic [CW-1:0]       cnt_inc;
    logic [SIZE_W:0]     size_sum;
    logic                big, two;
    logic [6:0]          v7;
    logic [3:0]          tens, ones;
    logic [7:0]          tens_char, ones_char;
    logic                scan_done;

    bhc_count_mem #(
        .DEPTH (ALPHABET),
        .AW    (AW),
        .CW    (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wr_data),
        .i_clear   (mem_clear),
        .o_rd_data (mem_rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;
    assign ptr_in     = (32'(r_ptr) < ALPHABET);

    // count update arithmetic
    assign cnt_inc     = mem_rd_data + 1'b1;
    assign mem_wr_data = cnt_inc;
    assign size_sum    = {1'b0, r_size}
                       + ((mem_rd_data == '0) ? (SIZE_W+1)'(COST_NEW) : '0)
                       + ((cnt_inc == CW'(DIGIT_SPLIT)) ? (SIZE_W+1)'(1) : '0);

    // digit split of the scanned count
    assign big       = (32'(mem_rd_data) > TWO_DIGIT_MAX);
    assign two       = (32'(mem_rd_data) >= DIGIT_SPLIT);
    assign v7        = 7'(mem_rd_data);
    assign tens      = digit_tens(v7);
    assign ones      = 4'(v7 - 7'(tens) * 7'(DIGIT_SPLIT));
    assign tens_char = (!big && two) ? (ASCII_ZERO + 8'(tens)) : '0;
    assign ones_char = !big ? (ASCII_ZERO + 8'(ones)) : '0;

    assign scan_done = (r_state == S_SCAN) && !ptr_in && out_free;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_len       = r_len;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_ptr[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_clear   = 1'b0;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_last = i_s_tlast;
                    if (i_s_tuser[0]) begin
                        // drain: fetch entry under the pointer
                        mem_rd_en   = ptr_in;
                        mem_rd_addr = r_ptr[AW-1:0];
                        n_state     = S_SCAN;
                    end else if (32'(r_len) >= MAX_LEN) begin
                        n_ovf   = 1'b1;
                        n_state = i_s_tlast ? S_SUM : S_IDLE;
                    end else if (32'(i_s_tdata) >= ALPHABET) begin
                        n_state = i_s_tlast ? S_SUM : S_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = i_s_tdata[AW-1:0];
                        n_addr      = i_s_tdata[AW-1:0];
                        n_state     = S_UPD;
                    end
                end
            end
            S_UPD: begin
                mem_wr_en = 1'b1;
                n_len     = r_len + 1'b1;
                n_size    = size_sum[SIZE_W] ? SIZE_W'(SIZE_MAX) : size_sum[SIZE_W-1:0];
                n_state   = r_last ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SUMMARY;
                    n_out_data  = (OUT_BYTES*8)'({r_ovf,
                                                 (32'(r_size) < 32'(r_len)),
                                                 r_size,
                                                 1'b0, 1'b0, 8'd0, 8'd0,
                                                 CW'(0), 8'd0});
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                if (ptr_in && mem_rd_data != '0) begin
                    // non-empty entry: report it once the output is free
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_ENTRY;
                        n_out_data  = (OUT_BYTES*8)'({1'b0, 1'b0, SIZE_W'(0),
                                                     big, two, ones_char, tens_char,
                                                     mem_rd_data, 8'(r_ptr[AW-1:0])});
                        n_ptr       = r_ptr + 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (ptr_in) begin
                    // empty entry: step on and fetch the next one
                    n_ptr       = r_ptr + 1'b1;
                    mem_rd_en   = (32'(n_ptr) < ALPHABET);
                    mem_rd_addr = n_ptr[AW-1:0];
                end else if (out_free) begin
                    // end of table: report and clear everything
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DONE;
                    n_out_data  = '0;
                    mem_clear   = 1'b1;
                    n_size      = '0;
                    n_len       = '0;
                    n_ptr       = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_len       <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_len       <= n_len;
            r_ptr       <= n_ptr;
            r_ovf       <= n_ovf;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_addr     <= n_addr;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    // checks
    a_upd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state != S_UPD))
        else $error("count update held longer than one cycle");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |=> (r_size == '0 && r_len == '0 && r_ptr == '0 && !r_ovf))
        else $error("drain end did not clear state");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_LEN)
        else $error("input length beyond limit");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) <= ALPHABET)
        else $error("scan pointer beyond table");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && r_state == S_SCAN) |=> o_m_tvalid)
        else $error("pending result dropped during scan");

endmodule

`default_nettype wire

@@ src/bhc_count_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Count table: one synchronous memory plus a valid bit per entry.
// An entry that is not valid reads as zero, so a clear only resets the valid bits.
module bhc_count_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [CW-1:0] i_wr_data,
    input  wire logic          i_clear,
    output logic      [CW-1:0] o_rd_data
);

    logic [CW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [CW-1:0]    r_rd_data;
    logic             r_rd_valid;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits and registered read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ tb/bhc_tb_pkg.sv @@
`timescale 1ns / 1ps

package bhc_tb_pkg;

    // input tuser: what the word on the slave side asks for
    typedef enum logic [0:0] {
        CMD_BYTE  = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

endpackage

@@ tb/bhc_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream sides, keeps its own histogram and size tally, and
// compares every output word against the oldest word it expects.
module bhc_checker
    import bhc_pkg::*;
    import bhc_tb_pkg::*;
#(
    parameter int CW      = 13,
    parameter int DW      = 56,
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // data_byte
    input  wire logic [0:0]    i_s_tuser,   // cmd
    input  wire logic          i_s_tlast,   // last
    input  wire logic          i_m_tvalid,
    input  wire logic          i_m_tready,
    // symbol, count, tens_char, ones_char, two_digits, too_large,
    // compressed_len, use_compressed, overflow
    input  wire logic [DW-1:0] i_m_tdata,
    input  wire logic [1:0]    i_m_tuser,   // kind
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct {
        t_kind             kind;
        logic [7:0]        symbol;
        logic [CW-1:0]     count;
        logic [7:0]        tens_char;
        logic [7:0]        ones_char;
        logic              two_digits;
        logic              too_large;
        logic [SIZE_W-1:0] compressed_len;
        logic              use_cmp;
        logic              overflow;
    } t_word;

    // histogram and running size of the encoded form
    logic [CW-1:0] hist [256];
    int            size_acc;
    int            str_len;
    int            scan_idx;
    bit            len_ovf;
    t_word         awaited_words [$];
    int            fail_total = 0;

    function automatic t_word blank_word(t_kind k);
        t_word w;
        w.kind           = k;
        w.symbol         = '0;
        w.count          = '0;
        w.tens_char      = '0;
        w.ones_char      = '0;
        w.two_digits     = 1'b0;
        w.too_large      = 1'b0;
        w.compressed_len = '0;
        w.use_cmp        = 1'b0;
        w.overflow       = 1'b0;
        return w;
    endfunction

    function automatic t_word unpack_word(logic [DW-1:0] d, logic [1:0] k);
        t_word w;
        w.kind           = t_kind'(k);
        w.symbol         = d[7:0];
        w.count          = d[8 +: CW];
        w.tens_char      = d[8 + CW +: 8];
        w.ones_char      = d[16 + CW +: 8];
        w.two_digits     = d[24 + CW];
        w.too_large      = d[25 + CW];
        w.compressed_len = d[26 + CW +: SIZE_W];
        w.use_cmp        = d[26 + CW + SIZE_W];
        w.overflow       = d[27 + CW + SIZE_W];
        return w;
    endfunction

    task automatic clear_counts();
        foreach (hist[i]) hist[i] = '0;
        size_acc = 0;
        str_len  = 0;
        scan_idx = 0;
        len_ovf  = 1'b0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        fail_total++;
        if (fail_total <= 100)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // one string byte; a last byte yields the size summary
    task automatic tally_byte(logic [7:0] b, logic last);
        t_word w;
        if (str_len >= MAX_LEN) begin
            len_ovf = 1'b1;
        end else begin
            str_len++;
            if (hist[b] == 0)
                size_acc += COST_NEW;
            hist[b]++;
            if (hist[b] == DIGIT_SPLIT)
                size_acc += 1;
            if (size_acc > SIZE_MAX)
                size_acc = SIZE_MAX;
        end
        if (last) begin
            w = blank_word(KIND_SUMMARY);
            w.compressed_len = SIZE_W'(size_acc);
            w.use_cmp        = size_acc < str_len;
            w.overflow       = len_ovf;
            awaited_words.push_back(w);
        end
    endtask

    // scan forward to the next non-empty entry, or finish and clear
    task automatic next_entry();
        t_word w;
        int    c;
        bit    found;
        found = 1'b0;
        while (!found && scan_idx < 256) begin
            c = hist[scan_idx];
            if (c != 0) begin
                found = 1'b1;
                w = blank_word(KIND_ENTRY);
                w.symbol     = 8'(scan_idx);
                w.count      = CW'(c);
                w.two_digits = c >= DIGIT_SPLIT;
                w.too_large  = c > TWO_DIGIT_MAX;
                if (!w.too_large) begin
                    if (w.two_digits)
                        w.tens_char = 8'(ASCII_ZERO + c / DIGIT_SPLIT);
                    w.ones_char = 8'(ASCII_ZERO + c % DIGIT_SPLIT);
                end
            end
            scan_idx++;
        end
        if (!found) begin
            clear_counts();
            w = blank_word(KIND_DONE);
        end
        awaited_words.push_back(w);
    endtask

    task automatic check_word(t_word got);
        t_word want;
        if (awaited_words.size() == 0) begin
            report_mismatch("word with nothing awaited, kind", got.kind, -1);
            return;
        end
        want = awaited_words.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.symbol != want.symbol)
            report_mismatch("symbol", got.symbol, want.symbol);
        if (got.count != want.count)
            report_mismatch("count", got.count, want.count);
        if (got.tens_char != want.tens_char)
            report_mismatch("tens_char", got.tens_char, want.tens_char);
        if (got.ones_char != want.ones_char)
            report_mismatch("ones_char", got.ones_char, want.ones_char);
        if (got.two_digits != want.two_digits)
            report_mismatch("two_digits", got.two_digits, want.two_digits);
        if (got.too_large != want.too_large)
            report_mismatch("too_large", got.too_large, want.too_large);
        if (got.compressed_len != want.compressed_len)
            report_mismatch("compressed_len", got.compressed_len, want.compressed_len);
        if (got.use_cmp != want.use_cmp)
            report_mismatch("use_compressed", got.use_cmp, want.use_cmp);
        if (got.overflow != want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
    endtask

    // compare first so a fresh expectation never matches an older word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_counts();
            awaited_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_word(unpack_word(i_m_tdata, i_m_tuser));
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_DRAIN)
                    next_entry();
                else
                    tally_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending    <= awaited_words.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bhc_pkg::*;
    import bhc_tb_pkg::*;

    localparam int CW            = $clog2(MAX_LEN_DEF + 1);
    localparam int OUT_W         = 8 + CW + 8 + 8 + 1 + 1 + SIZE_W + 1 + 1;
    localparam int DW            = ((OUT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 60;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [7:0]    i_s_tdata;   // data_byte
    logic [0:0]    i_s_tuser;   // cmd
    logic          i_s_tlast;   // last
    logic          o_m_tvalid;
    logic          i_m_tready;
    // symbol, count, tens_char, ones_char, two_digits, too_large,
    // compressed_len, use_compressed, overflow
    logic [DW-1:0] o_m_tdata;
    logic [1:0]    o_m_tuser;   // kind

    int results_pending;
    int fail_count;
    int cycle_count = 0;

    // sender bookkeeping: which symbols sit in the table, where the drain is
    bit present [256];
    int cursor  = 0;
    int str_len = 0;
    int sent    = 0;
    bit table_cleared;
    bit tx_calm = 1'b0;

    byte_histogram_compressor u_top (.*);

    bhc_checker #(.CW(CW), .DW(DW), .MAX_LEN(MAX_LEN_DEF)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_pending    (results_pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: short bursts, short and long stalls, some steady stretches
    initial begin : result_stalls
        int r;
        i_m_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            i_m_tready <= 1'b1;
            if (r < 15) begin
                repeat ($urandom_range(50, 300)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_m_tready <= 1'b0;
                if (r < 85)
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one word on the slave side; valid stays high into the next word
    task automatic send_word(t_cmd cmd, logic [7:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        table_cleared = 1'b0;
        if (cmd == CMD_BYTE) begin
            if (str_len < MAX_LEN_DEF) begin
                str_len++;
                present[b] = 1'b1;
            end
        end else begin
            while (cursor < 256 && !present[cursor])
                cursor++;
            if (cursor < 256) begin
                cursor++;
            end else begin
                foreach (present[i]) present[i] = 1'b0;
                cursor        = 0;
                str_len       = 0;
                table_cleared = 1'b1;
            end
        end
    endtask

    task automatic drain_to_end();
        do send_word(CMD_DRAIN, 8'($urandom), 1'($urandom)); while (!table_cleared);
    endtask

    // hold off until every awaited word has come back
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
    endtask

    // pool_n 0: any byte; else bytes from a pool of that many symbols
    task automatic send_string(int len, int pool_n);
        logic [7:0] pool [4];
        logic [7:0] b;
        foreach (pool[i]) pool[i] = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            b = (pool_n == 0) ? 8'($urandom) : pool[$urandom_range(0, pool_n - 1)];
            send_word(CMD_BYTE, b, i == len - 1);
        end
    endtask

    initial begin : stimulus
        int         pick;
        int         r;
        int         len;
        int         pool_n;
        int         rnd_start;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_BYTE;
        i_s_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drain of an empty table
        send_word(CMD_DRAIN, 8'h00, 1'b0);
        // extreme symbols, then more bytes after the last one
        send_word(CMD_BYTE, 8'h00, 1'b0);
        send_word(CMD_BYTE, 8'hFF, 1'b1);
        send_word(CMD_BYTE, 8'hFF, 1'b0);
        send_word(CMD_BYTE, 8'h00, 1'b1);
        // drain before the string ends, then keep counting
        send_word(CMD_DRAIN, 8'hFF, 1'b1);
        send_word(CMD_BYTE, 8'h80, 1'b1);
        drain_to_end();
        // count reaching ten needs a second digit
        for (int i = 0; i < 10; i++)
            send_word(CMD_BYTE, 8'h5A, i == 9);
        drain_to_end();
        wait_idle();

        // random strings, noise and drains
        rnd_start = sent;
        while (sent < rnd_start + RANDOM_ITEMS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    len = $urandom_range(1, 24);
                else if (r < 95)
                    len = $urandom_range(25, 200);
                else
                    len = $urandom_range(201, 600);
                pool_n = $urandom_range(0, 4);
                send_string(len, pool_n);
                if ($urandom_range(0, 9) == 0)
                    send_string($urandom_range(1, 8), pool_n);
                if ($urandom_range(0, 9) < 8) begin
                    drain_to_end();
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_DRAIN, 8'($urandom), 1'($urandom));
                end
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 10))
                    send_word(($urandom_range(0, 2) == 0) ? CMD_DRAIN : CMD_BYTE,
                              8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                drain_to_end();
            end
            if ($urandom_range(0, 19) == 0)
                wait_idle();
        end
        drain_to_end();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
src/bhc_pkg.sv
src/bhc_count_mem.sv
src/byte_histogram_compressor.sv
tb/bhc_tb_pkg.sv
tb/bhc_checker.sv
tb/testbench.sv
